// ===== rtl/core/sparse_adadelta_update_unit_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef SPARSE_ADADELTA_UPDATE_UNIT_MACROS_SVH
`define SPARSE_ADADELTA_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SAU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SAU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sau_pkg.sv =====
// Shared constants, codes and fixed-point helpers of the sparse Adadelta unit.
package sau_pkg;

   localparam int VW        = 32;
   localparam int FRAC      = 24;
   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_MAX_COLS = 16;
   localparam int PROD_W    = 74;
   localparam int QT_W      = 50;
   localparam int ITER_W    = 62;
   localparam int DEN_W     = 29;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 31;

   localparam logic [24:0] ONE_Q = 25'd16777216;

   localparam logic [1:0] REQ_APPLY = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] ST_APPLIED = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_LOADED  = 2'd2;
   localparam logic [1:0] ST_READ    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 3'd4;

   localparam logic MODE_DIV  = 1'b0;
   localparam logic MODE_SQRT = 1'b1;

   typedef struct packed {
      logic start;
      logic mode;
   } iter_ctl_type;

   // Q8.24 product scaled back, truncating toward zero.
   function automatic logic signed [QT_W-1:0] qtrunc(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] t;
      t = p + (p[PROD_W-1] ? PROD_W'(24'hFFFFFF) : PROD_W'(0));
      return t[PROD_W-1:FRAC];
   endfunction

   // Clamp to the signed value range.
   function automatic logic signed [VW-1:0] sat52(input logic signed [51:0] x);
      if (x > 52'sh0_0000_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (x < -52'sh0_0000_8000_0000)
         return 32'sh8000_0000;
      else
         return x[VW-1:0];
   endfunction

endpackage

// ===== rtl/core/sau_channels.sv =====
// Request and response channel interfaces.
interface sau_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic signed [sau_pkg::VW-1:0] row_index;
   logic [3:0]                    col_index;
   logic signed [sau_pkg::VW-1:0] grad_value;
   logic signed [sau_pkg::VW-1:0] load_param;
   logic signed [sau_pkg::VW-1:0] load_sq_grad_avg;
   logic signed [sau_pkg::VW-1:0] load_sq_update_avg;

   modport source (output valid, req_type, row_index, col_index, grad_value,
                   load_param, load_sq_grad_avg, load_sq_update_avg, input ready);
   modport sink   (input valid, req_type, row_index, col_index, grad_value,
                   load_param, load_sq_grad_avg, load_sq_update_avg, output ready);
endinterface

interface sau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic signed [sau_pkg::VW-1:0] param_out;
   logic signed [sau_pkg::VW-1:0] sq_grad_avg_out;
   logic signed [sau_pkg::VW-1:0] sq_update_avg_out;

   modport source (output valid, status, param_out, sq_grad_avg_out, sq_update_avg_out,
                   input ready);
   modport sink   (input valid, status, param_out, sq_grad_avg_out, sq_update_avg_out,
                   output ready);
endinterface

// ===== rtl/core/sparse_adadelta_update_unit.sv =====
// Top level of the sparse Adadelta update unit: sequencer, tables, config.
//
//  channel   dir  handshake        payload
//  req_chan  in   valid/ready      req_type, row_index, col_index, grad_value, load_*
//  rsp_chan  out  valid/ready      status, param_out, sq_grad_avg_out, sq_update_avg_out
//  csr_*     in   csr_we only      csr_index, csr_wdata
//
// An apply uses the shared iteration unit for two 29-step square roots and one
// 62-step divide, with sequencer states around the shared multiplier; the divide is
// skipped when the denominator root is zero.
// One request is in flight at a time; req ready is high only in idle.
// A finished response sits in the output register while the next request is taken;
// the sequencer stalls in its final state while that register is full and not taken.
// Reset is synchronous; tables are not cleared and must be loaded before use.
module sparse_adadelta_update_unit #(
   parameter int MAX_ROWS = sau_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = sau_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   sau_req_if.sink                             req_chan,
   sau_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [sau_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sau_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [4:0] S_IDLE = 5'd0,  S_RD   = 5'd1,  S_DEC  = 5'd2,  S_A1  = 5'd3,
                          S_A2   = 5'd4,  S_A3   = 5'd5,  S_A4   = 5'd6,  S_A5  = 5'd7,
                          S_SQ1  = 5'd8,  S_SQ1W = 5'd9,  S_SQ2  = 5'd10, S_SQ2W = 5'd11,
                          S_M4   = 5'd12, S_M4B  = 5'd13, S_DV   = 5'd14, S_DVW = 5'd15,
                          S_M5   = 5'd16, S_M6   = 5'd17, S_M7   = 5'd18, S_M8  = 5'd19,
                          S_M9   = 5'd20, S_M10  = 5'd21, S_WB   = 5'd22, S_FIN = 5'd23;

   // configuration
   logic [30:0] lr_ff;
   logic [24:0] rho_ff;
   logic [30:0] eps_ff;
   logic [8:0]  rows_ff;
   logic [4:0]  cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= 31'd16777216;
         rho_ff  <= 25'd15938355;
         eps_ff  <= 31'd17;
         rows_ff <= 9'd256;
         cols_ff <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            sau_pkg::CSR_LR:   lr_ff   <= csr_wdata;
            sau_pkg::CSR_RHO:  rho_ff  <= csr_wdata[24:0];
            sau_pkg::CSR_EPS:  eps_ff  <= csr_wdata;
            sau_pkg::CSR_ROWS: rows_ff <= csr_wdata[8:0];
            sau_pkg::CSR_COLS: cols_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic [8:0]  rows_eff;
   logic [4:0]  cols_eff;
   logic [24:0] rho_eff, omr;
   assign rows_eff = (32'(rows_ff) < MAX_ROWS) ? rows_ff : 9'(MAX_ROWS);
   assign cols_eff = (32'(cols_ff) < MAX_COLS) ? cols_ff : 5'(MAX_COLS);
   assign rho_eff  = (rho_ff > sau_pkg::ONE_Q) ? sau_pkg::ONE_Q : rho_ff;
   assign omr      = sau_pkg::ONE_Q - rho_eff;

   // request decode
   logic          in_range;
   logic [13:0]   addr_full;
   logic          req_xfer;
   assign in_range  = !req_chan.row_index[31]
                      && (req_chan.row_index[30:0] < 31'(rows_eff))
                      && (5'(req_chan.col_index) < cols_eff);
   assign addr_full = 14'(req_chan.row_index[8:0]) * 14'(cols_eff) + 14'(req_chan.col_index);

   logic [4:0]                    state_ff, state_in;
   logic [AW-1:0]                 addr_ff;
   logic [1:0]                    type_ff, status_ff;
   logic signed [31:0]            g_ff, par_ff, acc_ff, acu_ff;
   logic signed [sau_pkg::QT_W-1:0] t1_ff, gq_ff;
   logic [28:0]                   su_ff, sa_ff;
   logic signed [60:0]            num_ff;
   logic signed [31:0]            upd_ff;
   logic                          rsp_valid_ff;
   logic [1:0]                    rsp_status_ff;
   logic signed [31:0]            rsp_par_ff, rsp_acc_ff, rsp_acu_ff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // shared multiplier
   logic signed [40:0]                 mul_a;
   logic signed [32:0]                 mul_b;
   logic signed [sau_pkg::PROD_W-1:0]  prod_ff;
   logic signed [sau_pkg::QT_W-1:0]    prod_q;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_A1: begin mul_a = 41'(acc_ff); mul_b = 33'(rho_eff); end
         S_A2: begin mul_a = 41'(g_ff);   mul_b = 33'(g_ff); end
         S_A4: begin mul_a = 41'(gq_ff);  mul_b = 33'(omr); end
         S_M4: begin mul_a = 41'(su_ff);  mul_b = 33'(g_ff); end
         S_M5: begin mul_a = 41'(upd_ff); mul_b = 33'(lr_ff); end
         S_M6: begin mul_a = 41'(acu_ff); mul_b = 33'(rho_eff); end
         S_M7: begin mul_a = 41'(upd_ff); mul_b = 33'(upd_ff); end
         S_M9: begin mul_a = 41'(gq_ff);  mul_b = 33'(omr); end
         default: ;
      endcase
   end

   sau_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod_ff));
   assign prod_q = sau_pkg::qtrunc(prod_ff);

   // shared root / divide unit
   sau_pkg::iter_ctl_type           it_ctl;
   logic [sau_pkg::ITER_W-1:0]      it_arg, it_res;
   logic                            it_done;
   logic signed [32:0]              root_sum;
   logic [31:0]                     root_pos;

   always_comb begin
      root_sum = (state_ff == S_SQ1) ? 33'(acu_ff) + 33'(eps_ff)
                                     : 33'(acc_ff) + 33'(eps_ff);
      root_pos = (root_sum <= 0) ? 32'd0 : root_sum[31:0];
      it_ctl.start = (state_ff == S_SQ1) || (state_ff == S_SQ2)
                     || ((state_ff == S_DV) && (sa_ff != '0));
      it_ctl.mode  = (state_ff == S_DV) ? sau_pkg::MODE_DIV : sau_pkg::MODE_SQRT;
      if (state_ff == S_DV)
         it_arg = {1'b0, (num_ff[60] ? -num_ff : num_ff)};
      else
         it_arg = {2'b00, root_pos, 24'd0, 4'd0};
   end

   sau_iter u_iter (.clock(clock), .reset(reset), .ctl(it_ctl), .arg(it_arg),
                    .den(sa_ff), .done(it_done), .result(it_res));

   // signed quotient with saturation; divisor is positive here
   logic signed [31:0] q_sat;
   always_comb begin
      if (num_ff[60])
         q_sat = (it_res > 62'h8000_0000) ? 32'sh8000_0000 : -(it_res[31:0]);
      else
         q_sat = (it_res > 62'h7FFF_FFFF) ? 32'sh7FFF_FFFF : it_res[31:0];
   end

   // tables
   logic signed [31:0] par_mem [DEPTH];
   logic signed [31:0] acc_mem [DEPTH];
   logic signed [31:0] acu_mem [DEPTH];

   always_ff @(posedge clock) begin
      if ((state_ff == S_RD && type_ff == sau_pkg::REQ_LOAD) || state_ff == S_WB) begin
         par_mem[addr_ff] <= par_ff;
         acc_mem[addr_ff] <= acc_ff;
         acu_mem[addr_ff] <= acu_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_xfer) state_in = in_range ? S_RD : S_FIN;
         S_RD:    state_in = (type_ff == sau_pkg::REQ_LOAD) ? S_FIN : S_DEC;
         S_DEC:   state_in = (type_ff == sau_pkg::REQ_APPLY) ? S_A1 : S_FIN;
         S_A1:    state_in = S_A2;
         S_A2:    state_in = S_A3;
         S_A3:    state_in = S_A4;
         S_A4:    state_in = S_A5;
         S_A5:    state_in = S_SQ1;
         S_SQ1:   state_in = S_SQ1W;
         S_SQ1W:  if (it_done) state_in = S_SQ2;
         S_SQ2:   state_in = S_SQ2W;
         S_SQ2W:  if (it_done) state_in = S_M4;
         S_M4:    state_in = S_M4B;
         S_M4B:   state_in = S_DV;
         S_DV:    state_in = (sa_ff == '0) ? S_M5 : S_DVW;
         S_DVW:   if (it_done) state_in = S_M5;
         S_M5:    state_in = S_M6;
         S_M6:    state_in = S_M7;
         S_M7:    state_in = S_M8;
         S_M8:    state_in = S_M9;
         S_M9:    state_in = S_M10;
         S_M10:   state_in = S_WB;
         S_WB:    state_in = S_FIN;
         S_FIN:   if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (req_xfer) begin
            addr_ff <= AW'(addr_full);
            type_ff <= req_chan.req_type;
            g_ff    <= req_chan.grad_value;
            par_ff  <= req_chan.load_param;
            acc_ff  <= req_chan.load_sq_grad_avg;
            acu_ff  <= req_chan.load_sq_update_avg;
            if (!in_range)
               status_ff <= sau_pkg::ST_DROPPED;
            else if (req_chan.req_type == sau_pkg::REQ_APPLY)
               status_ff <= sau_pkg::ST_APPLIED;
            else if (req_chan.req_type == sau_pkg::REQ_LOAD)
               status_ff <= sau_pkg::ST_LOADED;
            else
               status_ff <= sau_pkg::ST_READ;
         end
         S_RD: if (type_ff != sau_pkg::REQ_LOAD) begin
            par_ff <= par_mem[addr_ff];
            acc_ff <= acc_mem[addr_ff];
            acu_ff <= acu_mem[addr_ff];
         end
         S_A2:   t1_ff  <= prod_q;
         S_A3:   gq_ff  <= prod_q;
         S_A5:   acc_ff <= sau_pkg::sat52(52'(t1_ff) + 52'(prod_q));
         S_SQ1W: if (it_done) su_ff <= it_res[28:0];
         S_SQ2W: if (it_done) sa_ff <= it_res[28:0];
         S_M4B:  num_ff <= prod_ff[60:0];
         S_DV: if (sa_ff == '0) begin
            if (num_ff == '0)
               upd_ff <= '0;
            else
               upd_ff <= num_ff[60] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end
         S_DVW:  if (it_done) upd_ff <= q_sat;
         S_M6:   par_ff <= sau_pkg::sat52(52'(par_ff) - 52'(prod_q));
         S_M7:   t1_ff  <= prod_q;
         S_M8:   gq_ff  <= prod_q;
         S_M10:  acu_ff <= sau_pkg::sat52(52'(t1_ff) + 52'(prod_q));
         default: ;
      endcase
   end

   // output register
   logic rsp_load;
   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_ff <= 1'b0;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         if (status_ff == sau_pkg::ST_DROPPED) begin
            rsp_par_ff <= '0;
            rsp_acc_ff <= '0;
            rsp_acu_ff <= '0;
         end else begin
            rsp_par_ff <= par_ff;
            rsp_acc_ff <= acc_ff;
            rsp_acu_ff <= acu_ff;
         end
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.param_out         = rsp_par_ff;
   assign rsp_chan.sq_grad_avg_out   = rsp_acc_ff;
   assign rsp_chan.sq_update_avg_out = rsp_acu_ff;
endmodule

// ===== rtl/core/sau_mul.sv =====
// Shared signed multiplier with registered product.
module sau_mul (
   input  logic                                clock,
   input  logic signed [40:0]                  op_a,
   input  logic signed [32:0]                  op_b,
   output logic signed [sau_pkg::PROD_W-1:0]   prod_ff
);
   logic signed [sau_pkg::PROD_W-1:0] prod_in;

   assign prod_in = sau_pkg::PROD_W'(op_a) * sau_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ===== rtl/core/sau_iter.sv =====
// Iterative square root / unsigned divide sharing one subtractor.
module sau_iter (
   input  logic                              clock,
   input  logic                              reset,
   input  sau_pkg::iter_ctl_type             ctl,
   input  logic [sau_pkg::ITER_W-1:0]        arg,
   input  logic [sau_pkg::DEN_W-1:0]         den,
   output logic                              done,
   output logic [sau_pkg::ITER_W-1:0]        result
);
   localparam logic [5:0] SQRT_STEPS = 6'd28;
   localparam logic [5:0] DIV_STEPS  = 6'd61;

   logic                          busy_ff, busy_in;
   logic                          mode_ff, mode_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic [sau_pkg::ITER_W-1:0]    x_ff, x_in;
   logic [33:0]                   rem_ff, rem_in;
   logic [29:0]                   root_ff, root_in;
   logic [sau_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [33:0]                   sh, sub;
   logic [34:0]                   diff;
   logic                          ge;

   always_comb begin
      if (mode_ff == sau_pkg::MODE_SQRT) begin
         sh  = {rem_ff[31:0], x_ff[61:60]};
         sub = 34'({root_ff, 2'b01});
      end else begin
         sh  = {rem_ff[32:0], x_ff[61]};
         sub = 34'(den_ff);
      end
      diff = {1'b0, sh} - {1'b0, sub};
      ge   = !diff[34];
   end

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         cnt_in  = (ctl.mode == sau_pkg::MODE_SQRT) ? SQRT_STEPS : DIV_STEPS;
         x_in    = arg;
         rem_in  = '0;
         root_in = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[33:0] : sh;
         if (mode_ff == sau_pkg::MODE_SQRT) begin
            root_in = {root_ff[28:0], ge};
            x_in    = {x_ff[59:0], 2'b00};
         end else begin
            x_in = {x_ff[60:0], ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      den_ff  <= den_in;
   end

   assign done   = busy_ff && !busy_in && !ctl.start;
   assign result = (mode_ff == sau_pkg::MODE_SQRT) ? sau_pkg::ITER_W'(root_in) : x_in;
endmodule

// ===== rtl/core/sau_checker.sv =====
// Port-level checks of the sparse Adadelta unit, bound to the top level.
`include "sparse_adadelta_update_unit_macros.svh"

module sau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_param,
   input logic [31:0] rsp_grad,
   input logic [31:0] rsp_upd
);
   `SAU_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
   `SAU_ASSERT_IMP(a_drop_zero, rsp_valid && rsp_status == sau_pkg::ST_DROPPED, rsp_param == 32'd0 && rsp_grad == 32'd0 && rsp_upd == 32'd0, "dropped response carries data")
   `SAU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_param), "stalled response changed")
   `SAU_ASSERT_NXT(a_no_early_rsp, req_valid && req_ready, !(rsp_valid && !$past(rsp_valid) && $rose(rsp_valid)), "response in cycle after request")
endmodule

bind sparse_adadelta_update_unit sau_checker u_sau_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status), .rsp_param(rsp_chan.param_out),
   .rsp_grad(rsp_chan.sq_grad_avg_out), .rsp_upd(rsp_chan.sq_update_avg_out)
);
